### hdl/bps_pkg.sv
package bps_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 1024;
  localparam int ADDRESS_BITS  = 32;
  localparam int ADDR_IN_W     = 32;
  localparam int TOTAL_W       = 32;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int ADDR_USED     = (ADDRESS_BITS < ADDR_IN_W) ? ADDRESS_BITS : ADDR_IN_W;
  localparam int TAG_W         = ADDR_USED - 2 - IDX_W;
  localparam int CTR_W         = 2;

  // Saturating counter codes
  localparam logic [CTR_W-1:0] CTR_STRONG_NOT   = 2'd0;
  localparam logic [CTR_W-1:0] CTR_WEAK_NOT     = 2'd1;
  localparam logic [CTR_W-1:0] CTR_WEAK_TAKEN   = 2'd2;
  localparam logic [CTR_W-1:0] CTR_STRONG_TAKEN = 2'd3;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // One table entry
  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic             dir;
    logic [CTR_W-1:0] ctr;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic             clr_en;
    logic [IDX_W-1:0] clr_idx;
    logic             capture;
    logic             commit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_hold;
  } stat_t;

endpackage

### hdl/bps_if.sv
interface bps_in_if;
  logic                           valid;
  logic                           ready;
  logic [bps_pkg::ADDR_IN_W-1:0]  branch_address;
  logic                           outcome_taken;

  modport source (output valid, output branch_address, output outcome_taken, input ready);
  modport sink   (input valid, input branch_address, input outcome_taken, output ready);
endinterface

interface bps_out_if;
  logic                         valid;
  logic                         ready;
  logic                         entry_found;
  logic                         one_bit_guess;
  logic                         two_bit_guess;
  logic                         one_bit_right;
  logic                         two_bit_right;
  logic [bps_pkg::TOTAL_W-1:0]  branches_seen;
  logic [bps_pkg::TOTAL_W-1:0]  taken_seen;
  logic [bps_pkg::TOTAL_W-1:0]  scored_seen;
  logic [bps_pkg::TOTAL_W-1:0]  one_bit_hits;
  logic [bps_pkg::TOTAL_W-1:0]  two_bit_hits;

  modport source (output valid, output entry_found, output one_bit_guess,
                  output two_bit_guess, output one_bit_right, output two_bit_right,
                  output branches_seen, output taken_seen, output scored_seen,
                  output one_bit_hits, output two_bit_hits, input ready);
  modport sink   (input valid, input entry_found, input one_bit_guess,
                  input two_bit_guess, input one_bit_right, input two_bit_right,
                  input branches_seen, input taken_seen, input scored_seen,
                  input one_bit_hits, input two_bit_hits, output ready);
endinterface

### hdl/bps_ctrl.sv
module bps_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  bps_pkg::stat_t stat,
  output bps_pkg::cmd_t  cmd
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCORE = 2'd2;

  localparam logic [bps_pkg::IDX_W-1:0] CLR_LAST =
    bps_pkg::IDX_W'(bps_pkg::TABLE_ENTRIES - 1);

  logic [1:0]                state_r, state_nxt;
  logic [bps_pkg::IDX_W-1:0] clr_idx_r, clr_idx_nxt;

  // Take a beat only when the table is cleared and no item is in flight
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    cmd         = '0;
    cmd.clr_idx = clr_idx_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_en  = 1'b1;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_SCORE;
        end
      end
      ST_SCORE: begin
        // Hold while the previous result has not been taken
        if (!stat.out_hold) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_capture_to_score: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == ST_SCORE)
    else $error("capture not followed by score");

  a_clear_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_en |-> !cmd.capture && !cmd.commit && !in_ready)
    else $error("clearing overlaps item traffic");

  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !stat.out_hold)
    else $error("commit while result register still held");
`endif

endmodule

### hdl/bps_datapath.sv
module bps_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bps_pkg::cmd_t                   cmd,
  output bps_pkg::stat_t                  stat,
  input  logic [bps_pkg::ADDR_IN_W-1:0]   in_addr,
  input  logic                            in_taken,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_found,
  output logic                            out_g1,
  output logic                            out_g2,
  output logic                            out_r1,
  output logic                            out_r2,
  output logic [bps_pkg::TOTAL_W-1:0]     out_branches,
  output logic [bps_pkg::TOTAL_W-1:0]     out_taken_cnt,
  output logic [bps_pkg::TOTAL_W-1:0]     out_scored,
  output logic [bps_pkg::TOTAL_W-1:0]     out_one_hits,
  output logic [bps_pkg::TOTAL_W-1:0]     out_two_hits
);

  localparam int IDX_LO = 2;
  localparam int TAG_LO = 2 + bps_pkg::IDX_W;

  bps_pkg::entry_t mem [bps_pkg::TABLE_ENTRIES];

  bps_pkg::entry_t              rd_r;
  logic [bps_pkg::IDX_W-1:0]    idx_r;
  logic [bps_pkg::TAG_W-1:0]    tag_r;
  logic                         taken_r;

  logic [bps_pkg::TOTAL_W-1:0]  branch_total_r, taken_total_r, scored_total_r;
  logic [bps_pkg::TOTAL_W-1:0]  one_total_r, two_total_r;
  logic                         out_valid_r;
  logic                         found_r, g1_r, g2_r, r1_r, r2_r;

  logic                         hit, g1, g2, r1, r2;
  logic [bps_pkg::CTR_W-1:0]    ctr_nxt;
  bps_pkg::entry_t              wr_entry;

  function automatic logic [bps_pkg::TOTAL_W-1:0] sat_inc(
    input logic [bps_pkg::TOTAL_W-1:0] v
  );
    return (v == bps_pkg::TOTAL_MAX) ? v : v + 1'b1;
  endfunction

  // Capture the item and read its table entry
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_r    <= mem[in_addr[IDX_LO +: bps_pkg::IDX_W]];
      idx_r   <= in_addr[IDX_LO +: bps_pkg::IDX_W];
      tag_r   <= in_addr[TAG_LO +: bps_pkg::TAG_W];
      taken_r <= in_taken;
    end
  end

  // Score against the entry as read
  always_comb begin
    hit = rd_r.valid && (rd_r.tag == tag_r);
    g1  = hit & rd_r.dir;
    g2  = hit & rd_r.ctr[1];
    r1  = hit & (g1 == taken_r);
    r2  = hit & (g2 == taken_r);
    if (!hit) begin
      ctr_nxt = taken_r ? bps_pkg::CTR_WEAK_TAKEN : bps_pkg::CTR_WEAK_NOT;
    end else if (taken_r) begin
      ctr_nxt = (rd_r.ctr == bps_pkg::CTR_STRONG_TAKEN) ? rd_r.ctr : rd_r.ctr + 1'b1;
    end else begin
      ctr_nxt = (rd_r.ctr == bps_pkg::CTR_STRONG_NOT) ? rd_r.ctr : rd_r.ctr - 1'b1;
    end
    wr_entry.valid = 1'b1;
    wr_entry.tag   = tag_r;
    wr_entry.dir   = taken_r;
    wr_entry.ctr   = ctr_nxt;
  end

  // Write back the entry, or clear one during the sweep
  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      mem[cmd.clr_idx] <= '0;
    end else if (cmd.commit) begin
      mem[idx_r] <= wr_entry;
    end
  end

  // Advance the running totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      branch_total_r <= '0;
      taken_total_r  <= '0;
      scored_total_r <= '0;
      one_total_r    <= '0;
      two_total_r    <= '0;
    end else if (cmd.commit) begin
      branch_total_r <= sat_inc(branch_total_r);
      if (taken_r) taken_total_r <= sat_inc(taken_total_r);
      if (hit)     scored_total_r <= sat_inc(scored_total_r);
      if (r1)      one_total_r <= sat_inc(one_total_r);
      if (r2)      two_total_r <= sat_inc(two_total_r);
    end
  end

  // Result register: load on commit, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      found_r <= hit;
      g1_r    <= g1;
      g2_r    <= g2;
      r1_r    <= r1;
      r2_r    <= r2;
    end
  end

  assign stat.out_hold = out_valid_r && !out_ready;

  assign out_valid     = out_valid_r;
  assign out_found     = found_r;
  assign out_g1        = g1_r;
  assign out_g2        = g2_r;
  assign out_r1        = r1_r;
  assign out_r2        = r2_r;
  assign out_branches  = branch_total_r;
  assign out_taken_cnt = taken_total_r;
  assign out_scored    = scored_total_r;
  assign out_one_hits  = one_total_r;
  assign out_two_hits  = two_total_r;

`ifndef ASSERT_OFF
  a_commit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("result not loaded after commit");

  a_scored_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    scored_total_r <= branch_total_r && taken_total_r <= branch_total_r)
    else $error("partial total exceeds branch total");

  a_hits_le_scored: assert property (@(posedge clk) disable iff (!rst_n)
    one_total_r <= scored_total_r && two_total_r <= scored_total_r)
    else $error("hit total exceeds scored total");
`endif

endmodule

### hdl/branch_predictor_scoreboard_unit.sv
// Channel  | Dir | Handshake     | Beat contents
// in_br    | in  | valid / ready | branch_address, outcome_taken
// out_res  | out | valid / ready | entry_found, guesses, right flags, five totals
//
// An item is handled in two steps: its table entry is read, then the item is
// scored, the entry written back and the result register loaded.
// A new beat is taken while the previous result still waits in the register.
// After reset a pass clearing all TABLE_ENTRIES (1024) entries wipes the valid
// bits; in_br.ready stays low until it ends. Reset is synchronous, active low.
// A stalled out_res holds the scoring step until its result register is free.
module branch_predictor_scoreboard_unit (
  input logic       clk,
  input logic       rst_n,
  bps_in_if.sink    in_br,
  bps_out_if.source out_res
);

  bps_pkg::cmd_t  cmd;
  bps_pkg::stat_t stat;
  logic           ready_w;

  bps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_br.valid),
    .in_ready (ready_w),
    .stat     (stat),
    .cmd      (cmd)
  );

  assign in_br.ready = ready_w;

  bps_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_addr       (in_br.branch_address),
    .in_taken      (in_br.outcome_taken),
    .out_valid     (out_res.valid),
    .out_ready     (out_res.ready),
    .out_found     (out_res.entry_found),
    .out_g1        (out_res.one_bit_guess),
    .out_g2        (out_res.two_bit_guess),
    .out_r1        (out_res.one_bit_right),
    .out_r2        (out_res.two_bit_right),
    .out_branches  (out_res.branches_seen),
    .out_taken_cnt (out_res.taken_seen),
    .out_scored    (out_res.scored_seen),
    .out_one_hits  (out_res.one_bit_hits),
    .out_two_hits  (out_res.two_bit_hits)
  );

endmodule
